// ===== rtl/mat_pkg.sv =====
`timescale 1ns / 1ps

package mat_pkg;

    // Register map
    localparam logic [1:0] REG_IMAGE_WIDTH  = 2'd0;
    localparam logic [1:0] REG_IMAGE_HEIGHT = 2'd1;
    localparam logic [1:0] REG_WINDOW_RAD   = 2'd2;
    localparam logic [1:0] REG_THRESH_OFS   = 2'd3;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 13;

    // Register widths and reset values
    localparam int WIDTH_REG_W  = 12;
    localparam int HEIGHT_REG_W = 13;
    localparam int RADIUS_REG_W = 3;
    localparam int OFFSET_REG_W = 9;

    localparam logic [WIDTH_REG_W-1:0]  WIDTH_RESET  = 12'd1920;
    localparam logic [HEIGHT_REG_W-1:0] HEIGHT_RESET = 13'd1080;
    localparam logic [RADIUS_REG_W-1:0] RADIUS_RESET = 3'd5;
    localparam logic [OFFSET_REG_W-1:0] OFFSET_RESET = 9'd2;

    // Frame height limit
    localparam logic [HEIGHT_REG_W-1:0] MAX_HEIGHT = 13'd4096;
    localparam int ROW_W = 12;

    // Input commands
    localparam logic CMD_PIXEL = 1'b0;
    localparam logic CMD_FLUSH = 1'b1;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_CENTER,
        ST_SCAN,
        ST_DRAIN,
        ST_MUL,
        ST_DONE
    } state_t;

endpackage

// ===== rtl/mat_in_if.sv =====
`timescale 1ns / 1ps

interface mat_in_if;
    logic       valid;
    logic       ready;
    logic       cmd;
    logic [7:0] pixel_value;

    modport source (output valid, output cmd, output pixel_value, input ready);
    modport sink (input valid, input cmd, input pixel_value, output ready);
endinterface

// ===== rtl/mat_out_if.sv =====
`timescale 1ns / 1ps

interface mat_out_if;
    logic valid;
    logic ready;
    logic binary_pixel;
    logic end_of_frame;

    modport source (output valid, output binary_pixel, output end_of_frame, input ready);
    modport sink (input valid, input binary_pixel, input end_of_frame, output ready);
endinterface

// ===== rtl/mat_line_store.sv =====
`timescale 1ns / 1ps

module mat_line_store #(
    parameter int DEPTH  = 32768,
    parameter int ADDR_W = 15
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [7:0]        wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [7:0]        rdata
);

    logic [7:0] mem [DEPTH];
    logic [7:0] rdata_reg;

    // Write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/mean_adaptive_threshold_core.sv =====
`timescale 1ns / 1ps
// Channel    Dir   Words                          Handshake
// pix_in     in    cmd, pixel_value               valid/ready
// pix_out    out   binary_pixel, end_of_frame     valid/ready
// cfg        in    cfg_we, cfg_index, cfg_data    write enable only
//
// One word at a time: accept, a check state to test whether a result is due,
// then one line store read per window pixel plus the center pixel, a
// drain state, a multiply and a compare; a word with no result due goes
// back to accept after the check. The single read port of the line store
// sets this. Reset clears positions and loads register defaults; the store
// is not cleared. A result that finds the output register still full waits
// in the sequencer, and input stays blocked until the register frees.

module mean_adaptive_threshold_core #(
    parameter int MAX_WIDTH  = 2048,
    parameter int MAX_RADIUS = 7
) (
    input  logic                             clk,
    input  logic                             rst_n,
    mat_in_if.sink                           pix_in,
    mat_out_if.source                        pix_out,
    input  logic                             cfg_we,
    input  logic [mat_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [mat_pkg::CFG_DATA_W-1:0]   cfg_data
);

    localparam int SR     = 2 * MAX_RADIUS + 2;
    localparam int RGW    = $clog2(SR);
    localparam int DEPTH  = SR * MAX_WIDTH;
    localparam int AW     = $clog2(DEPTH);
    localparam int CLW    = $clog2(MAX_WIDTH);
    localparam int WEW    = $clog2(MAX_WIDTH + 1);
    localparam int WCW    = (WEW > mat_pkg::WIDTH_REG_W) ? WEW : mat_pkg::WIDTH_REG_W;
    localparam int RW     = $clog2(MAX_RADIUS + 1);
    localparam int SIDE   = 2 * MAX_RADIUS + 1;
    localparam int CNTW   = $clog2(SIDE * SIDE + 1);
    localparam int SUMW   = $clog2(SIDE * SIDE * 255 + 1);
    localparam int PW     = CNTW + 11;
    localparam int ROW_W  = mat_pkg::ROW_W;
    localparam int HW     = mat_pkg::HEIGHT_REG_W;

    // Configuration registers
    logic [mat_pkg::WIDTH_REG_W-1:0]  width_reg;
    logic [HW-1:0]                    height_reg;
    logic [mat_pkg::RADIUS_REG_W-1:0] radius_reg;
    logic [mat_pkg::OFFSET_REG_W-1:0] offset_reg;

    // Position state
    logic [CLW-1:0]   in_col_reg, in_col_next;
    logic [HW-1:0]    in_row_reg, in_row_next;
    logic [RGW-1:0]   in_ring_reg, in_ring_next;
    logic [CLW-1:0]   ox_reg, ox_next;
    logic [ROW_W-1:0] oy_reg, oy_next;
    logic [RGW-1:0]   oy_ring_reg, oy_ring_next;

    // Window scan state
    mat_pkg::state_t  state_reg, state_next;
    logic [CLW-1:0]   x_reg, x_next;
    logic [CLW-1:0]   xs_reg, xs_next;
    logic [CLW-1:0]   xe_reg, xe_next;
    logic [RGW-1:0]   ring_reg, ring_next;
    logic [RW:0]      rows_left_reg, rows_left_next;
    logic             acc_en_reg, acc_en_next;
    logic             ctr_en_reg, ctr_en_next;
    logic [SUMW-1:0]  sum_reg, sum_next;
    logic [CNTW-1:0]  cnt_reg, cnt_next;
    logic [7:0]       pix_reg, pix_next;
    logic signed [PW-1:0] prod_reg, prod_next;
    logic signed [9:0]    lhs_base;

    // Output register
    logic out_valid_reg, out_valid_next;
    logic out_bin_reg, out_bin_next;
    logic out_eof_reg, out_eof_next;

    // Line store ports
    logic          st_we;
    logic [AW-1:0] st_waddr;
    logic          st_re;
    logic [AW-1:0] st_raddr;
    logic [7:0]    st_rdata;

    // Effective geometry
    logic [WCW-1:0]   w_wide;
    logic [CLW:0]     w_eff;
    logic [CLW-1:0]   w_last;
    logic [HW-1:0]    h_eff;
    logic [ROW_W-1:0] h_last;
    logic [RW-1:0]    r_eff;

    // Window bounds for the current output position
    logic [ROW_W:0]   oy_plus;
    logic [ROW_W-1:0] ly;
    logic [CLW:0]     ox_plus;
    logic [CLW-1:0]   lx;
    logic [RW-1:0]    dy;
    logic [RW-1:0]    dx;
    logic [RGW:0]     ring_start;
    logic             due;
    logic             accept;
    logic             restart;

    mat_line_store #(
        .DEPTH  (DEPTH),
        .ADDR_W (AW)
    ) u_store (
        .clk   (clk),
        .we    (st_we),
        .waddr (st_waddr),
        .wdata (pix_in.pixel_value),
        .re    (st_re),
        .raddr (st_raddr),
        .rdata (st_rdata)
    );

    // Geometry clamps
    always_comb
    begin
        w_wide = WCW'(width_reg);
        if (width_reg == '0)
            w_eff = (CLW+1)'(1);
        else if (w_wide > WCW'(MAX_WIDTH))
            w_eff = (CLW+1)'(MAX_WIDTH);
        else
            w_eff = (CLW+1)'(width_reg);
        w_last = CLW'(w_eff - (CLW+1)'(1));

        if (height_reg == '0)
            h_eff = HW'(1);
        else if (height_reg > mat_pkg::MAX_HEIGHT)
            h_eff = mat_pkg::MAX_HEIGHT;
        else
            h_eff = height_reg;
        h_last = ROW_W'(h_eff - HW'(1));

        if (32'(radius_reg) > MAX_RADIUS)
            r_eff = RW'(MAX_RADIUS);
        else
            r_eff = RW'(radius_reg);
    end

    // Window bounds and readiness test
    always_comb
    begin
        oy_plus = (ROW_W+1)'(oy_reg) + (ROW_W+1)'(r_eff);
        ly = (oy_plus > (ROW_W+1)'(h_last)) ? h_last : ROW_W'(oy_plus);
        ox_plus = (CLW+1)'(ox_reg) + (CLW+1)'(r_eff);
        lx = (ox_plus > (CLW+1)'(w_last)) ? w_last : CLW'(ox_plus);
        dy = ((ROW_W+1)'(oy_reg) >= (ROW_W+1)'(r_eff)) ? r_eff : RW'(oy_reg);
        dx = ((CLW+1)'(ox_reg) >= (CLW+1)'(r_eff)) ? r_eff : RW'(ox_reg);
        if ((RGW+1)'(oy_ring_reg) >= (RGW+1)'(dy))
            ring_start = (RGW+1)'(oy_ring_reg) - (RGW+1)'(dy);
        else
            ring_start = (RGW+1)'(oy_ring_reg) + (RGW+1)'(SR) - (RGW+1)'(dy);
        due = (in_row_reg > HW'(ly))
              || ((in_row_reg == HW'(ly)) && (in_col_reg > lx));
    end

    assign accept  = pix_in.valid && pix_in.ready;
    assign restart = cfg_we && (cfg_index != mat_pkg::REG_THRESH_OFS);

    // Center pixel plus offset, signed
    assign lhs_base = $signed({2'b00, pix_reg}) + $signed({offset_reg[8], offset_reg});

    // Line store write on a pixel word inside the frame
    assign st_we    = accept && (pix_in.cmd == mat_pkg::CMD_PIXEL) && (in_row_reg < h_eff);
    assign st_waddr = AW'(in_ring_reg) * AW'(MAX_WIDTH) + AW'(in_col_reg);

    assign pix_in.ready       = (state_reg == mat_pkg::ST_IDLE);
    assign pix_out.valid        = out_valid_reg;
    assign pix_out.binary_pixel = out_bin_reg;
    assign pix_out.end_of_frame = out_eof_reg;

    // Sequencer
    always_comb
    begin
        state_next     = state_reg;
        in_col_next    = in_col_reg;
        in_row_next    = in_row_reg;
        in_ring_next   = in_ring_reg;
        ox_next        = ox_reg;
        oy_next        = oy_reg;
        oy_ring_next   = oy_ring_reg;
        x_next         = x_reg;
        xs_next        = xs_reg;
        xe_next        = xe_reg;
        ring_next      = ring_reg;
        rows_left_next = rows_left_reg;
        acc_en_next    = 1'b0;
        ctr_en_next    = 1'b0;
        sum_next       = sum_reg;
        cnt_next       = cnt_reg;
        pix_next       = pix_reg;
        prod_next      = prod_reg;
        out_valid_next = out_valid_reg && !pix_out.ready;
        out_bin_next   = out_bin_reg;
        out_eof_next   = out_eof_reg;
        st_re          = 1'b0;
        st_raddr       = AW'(ring_reg) * AW'(MAX_WIDTH) + AW'(x_reg);

        // Accumulate data returned from the store
        if (ctr_en_reg)
            pix_next = st_rdata;
        if (acc_en_reg)
        begin
            sum_next = sum_reg + SUMW'(st_rdata);
            cnt_next = cnt_reg + CNTW'(1);
        end

        unique case (state_reg)
            mat_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    if (st_we)
                    begin
                        if (in_col_reg == w_last)
                        begin
                            in_col_next = '0;
                            in_row_next = in_row_reg + HW'(1);
                            in_ring_next = (in_ring_reg == RGW'(SR - 1)) ? '0
                                         : in_ring_reg + RGW'(1);
                        end
                        else
                            in_col_next = in_col_reg + CLW'(1);
                    end
                    state_next = mat_pkg::ST_CHECK;
                end
            end
            mat_pkg::ST_CHECK:
            begin
                if (due && (HW'(oy_reg) < h_eff))
                begin
                    xs_next        = ox_reg - CLW'(dx);
                    xe_next        = lx;
                    ring_next      = RGW'(ring_start);
                    rows_left_next = (RW+1)'(ly - (oy_reg - ROW_W'(dy)));
                    state_next     = mat_pkg::ST_CENTER;
                end
                else
                    state_next = mat_pkg::ST_IDLE;
            end
            mat_pkg::ST_CENTER:
            begin
                st_re       = 1'b1;
                st_raddr    = AW'(oy_ring_reg) * AW'(MAX_WIDTH) + AW'(ox_reg);
                ctr_en_next = 1'b1;
                x_next      = xs_reg;
                sum_next    = '0;
                cnt_next    = '0;
                state_next  = mat_pkg::ST_SCAN;
            end
            mat_pkg::ST_SCAN:
            begin
                st_re       = 1'b1;
                acc_en_next = 1'b1;
                if (x_reg == xe_reg)
                begin
                    x_next = xs_reg;
                    if (rows_left_reg == '0)
                        state_next = mat_pkg::ST_DRAIN;
                    else
                    begin
                        rows_left_next = rows_left_reg - (RW+1)'(1);
                        ring_next = (ring_reg == RGW'(SR - 1)) ? '0 : ring_reg + RGW'(1);
                    end
                end
                else
                    x_next = x_reg + CLW'(1);
            end
            mat_pkg::ST_DRAIN:
            begin
                state_next = mat_pkg::ST_MUL;
            end
            mat_pkg::ST_MUL:
            begin
                prod_next = $signed({{(PW-10){lhs_base[9]}}, lhs_base})
                            * $signed({{(PW-CNTW){1'b0}}, cnt_reg});
                state_next = mat_pkg::ST_DONE;
            end
            mat_pkg::ST_DONE:
            begin
                if (!out_valid_reg || pix_out.ready)
                begin
                    out_valid_next = 1'b1;
                    out_bin_next   = prod_reg > $signed({{(PW-SUMW){1'b0}}, sum_reg});
                    out_eof_next   = (ox_reg == w_last) && (oy_reg == h_last);
                    if (out_eof_next)
                    begin
                        in_col_next  = '0;
                        in_row_next  = '0;
                        in_ring_next = '0;
                        ox_next      = '0;
                        oy_next      = '0;
                        oy_ring_next = '0;
                    end
                    else if (ox_reg == w_last)
                    begin
                        ox_next = '0;
                        oy_next = oy_reg + ROW_W'(1);
                        oy_ring_next = (oy_ring_reg == RGW'(SR - 1)) ? '0
                                     : oy_ring_reg + RGW'(1);
                    end
                    else
                        ox_next = ox_reg + CLW'(1);
                    state_next = mat_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = mat_pkg::ST_IDLE;
            end
        endcase

        // Geometry write drops the frame in progress
        if (restart)
        begin
            in_col_next  = '0;
            in_row_next  = '0;
            in_ring_next = '0;
            ox_next      = '0;
            oy_next      = '0;
            oy_ring_next = '0;
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= mat_pkg::ST_IDLE;
            width_reg     <= mat_pkg::WIDTH_RESET;
            height_reg    <= mat_pkg::HEIGHT_RESET;
            radius_reg    <= mat_pkg::RADIUS_RESET;
            offset_reg    <= mat_pkg::OFFSET_RESET;
            in_col_reg    <= '0;
            in_row_reg    <= '0;
            in_ring_reg   <= '0;
            ox_reg        <= '0;
            oy_reg        <= '0;
            oy_ring_reg   <= '0;
            acc_en_reg    <= 1'b0;
            ctr_en_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            in_col_reg    <= in_col_next;
            in_row_reg    <= in_row_next;
            in_ring_reg   <= in_ring_next;
            ox_reg        <= ox_next;
            oy_reg        <= oy_next;
            oy_ring_reg   <= oy_ring_next;
            acc_en_reg    <= acc_en_next;
            ctr_en_reg    <= ctr_en_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    mat_pkg::REG_IMAGE_WIDTH:
                        width_reg <= cfg_data[mat_pkg::WIDTH_REG_W-1:0];
                    mat_pkg::REG_IMAGE_HEIGHT:
                        height_reg <= cfg_data[HW-1:0];
                    mat_pkg::REG_WINDOW_RAD:
                        radius_reg <= cfg_data[mat_pkg::RADIUS_REG_W-1:0];
                    mat_pkg::REG_THRESH_OFS:
                        offset_reg <= cfg_data[mat_pkg::OFFSET_REG_W-1:0];
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        x_reg         <= x_next;
        xs_reg        <= xs_next;
        xe_reg        <= xe_next;
        ring_reg      <= ring_next;
        rows_left_reg <= rows_left_next;
        sum_reg       <= sum_next;
        cnt_reg       <= cnt_next;
        pix_reg       <= pix_next;
        prod_reg      <= prod_next;
        out_bin_reg   <= out_bin_next;
        out_eof_reg   <= out_eof_next;
    end

endmodule

// ===== tb/sv/mean_adaptive_threshold_checker.sv =====
`timescale 1ns / 1ps

module mean_adaptive_threshold_checker #(
    parameter int MAX_WIDTH  = 2048,
    parameter int MAX_RADIUS = 7
) (
    input  logic clk,
    input  logic rst_n,
    mat_in_if    pix_in,
    mat_out_if   pix_out,
    input  logic cfg_we,
    input  logic [mat_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [mat_pkg::CFG_DATA_W-1:0]  cfg_data,
    output int   errors,
    output int   pending
);

    localparam int STORE_ROWS = 2 * MAX_RADIUS + 2;
    localparam int MAX_H = 4096;

    typedef struct packed {
        logic white;
        logic eof;
    } bin_word_t;

    // Shadow registers and frame position
    logic [mat_pkg::WIDTH_REG_W-1:0]  width_q;
    logic [mat_pkg::HEIGHT_REG_W-1:0] height_q;
    logic [mat_pkg::RADIUS_REG_W-1:0] radius_q;
    logic signed [mat_pkg::OFFSET_REG_W-1:0] offset_q;
    int unsigned in_row, in_col, out_pos;

    logic [7:0] luma_rows [0:STORE_ROWS*MAX_WIDTH-1];
    bin_word_t  binary_q[$];

    assign pending = binary_q.size();

    function automatic int unsigned luma_at(input int unsigned y, input int unsigned x);
        return luma_rows[(y % STORE_ROWS) * MAX_WIDTH + x];
    endfunction

    // Takes one word in and queues the binary pixel it releases, if any
    task automatic threshold_step(input logic cmd, input logic [7:0] pix);
        int unsigned w, h, r, oy, ox, ly, lx, y0, x0, sum, cnt;
        int lhs;
        bin_word_t res;
        w = (width_q == 0) ? 1 : ((width_q > MAX_WIDTH) ? MAX_WIDTH : width_q);
        h = (height_q == 0) ? 1 : ((height_q > MAX_H) ? MAX_H : height_q);
        r = (radius_q > MAX_RADIUS) ? MAX_RADIUS : radius_q;
        if (in_col >= w)
        begin
            in_row = 0; in_col = 0; out_pos = 0;
        end
        if (cmd == mat_pkg::CMD_PIXEL && in_row < h)
        begin
            luma_rows[(in_row % STORE_ROWS) * MAX_WIDTH + in_col] = pix;
            in_col++;
            if (in_col >= w)
            begin
                in_col = 0;
                in_row++;
            end
        end
        oy = out_pos / w;
        ox = out_pos % w;
        if (oy >= h)
            return;
        ly = (oy + r > h - 1) ? h - 1 : oy + r;
        lx = (ox + r > w - 1) ? w - 1 : ox + r;
        // window not yet complete
        if (in_row * w + in_col <= ly * w + lx)
            return;
        y0 = (oy >= r) ? oy - r : 0;
        x0 = (ox >= r) ? ox - r : 0;
        sum = 0;
        for (int unsigned y = y0; y <= ly; y++)
            for (int unsigned x = x0; x <= lx; x++)
                sum += luma_at(y, x);
        cnt = (ly - y0 + 1) * (lx - x0 + 1);
        lhs = (int'(luma_at(oy, ox)) + int'(offset_q)) * int'(cnt);
        res.white = !(lhs <= int'(sum));
        out_pos++;
        res.eof = (out_pos == w * h);
        if (res.eof)
        begin
            in_row = 0; in_col = 0; out_pos = 0;
        end
        binary_q.push_back(res);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        bin_word_t exp_w;
        if (!rst_n)
        begin
            width_q  = mat_pkg::WIDTH_RESET;
            height_q = mat_pkg::HEIGHT_RESET;
            radius_q = mat_pkg::RADIUS_RESET;
            offset_q = mat_pkg::OFFSET_RESET;
            in_row = 0; in_col = 0; out_pos = 0;
            binary_q.delete();
            errors = 0;
        end
        else
        begin
            // result side first: a word never leaves on the edge it was caused
            if (pix_out.valid && pix_out.ready)
            begin
                if (binary_q.size() == 0)
                begin
                    $error("unexpected output word: binary_pixel=%0b end_of_frame=%0b",
                           pix_out.binary_pixel, pix_out.end_of_frame);
                    errors++;
                end
                else
                begin
                    exp_w = binary_q.pop_front();
                    if (pix_out.binary_pixel !== exp_w.white)
                    begin
                        $error("binary_pixel: expected %0b, got %0b",
                               exp_w.white, pix_out.binary_pixel);
                        errors++;
                    end
                    if (pix_out.end_of_frame !== exp_w.eof)
                    begin
                        $error("end_of_frame: expected %0b, got %0b",
                               exp_w.eof, pix_out.end_of_frame);
                        errors++;
                    end
                end
            end
            if (cfg_we)
            begin
                case (cfg_index)
                    mat_pkg::REG_IMAGE_WIDTH:
                    begin
                        width_q = cfg_data[mat_pkg::WIDTH_REG_W-1:0];
                        in_row = 0; in_col = 0; out_pos = 0;
                    end
                    mat_pkg::REG_IMAGE_HEIGHT:
                    begin
                        height_q = cfg_data[mat_pkg::HEIGHT_REG_W-1:0];
                        in_row = 0; in_col = 0; out_pos = 0;
                    end
                    mat_pkg::REG_WINDOW_RAD:
                    begin
                        radius_q = cfg_data[mat_pkg::RADIUS_REG_W-1:0];
                        in_row = 0; in_col = 0; out_pos = 0;
                    end
                    default:
                        offset_q = cfg_data[mat_pkg::OFFSET_REG_W-1:0];
                endcase
            end
            if (pix_in.valid && pix_in.ready)
                threshold_step(pix_in.cmd, pix_in.pixel_value);
        end
    end

endmodule

// ===== tb/sv/mean_adaptive_threshold_core_tb.sv =====
`timescale 1ns / 1ps

module mean_adaptive_threshold_core_tb;

    localparam int DRAIN_CYCLES = 300;
    localparam int CYCLE_LIMIT  = 4000000;
    localparam int RANDOM_WORDS = 850;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [mat_pkg::CFG_INDEX_W-1:0] cfg_index;
    logic [mat_pkg::CFG_DATA_W-1:0]  cfg_data;
    logic in_taken;
    int   errors, pending, cycles, burst_left, words_sent, stall_mode, stall_cnt;

    mat_in_if  in_ch ();
    mat_out_if out_ch ();

    mean_adaptive_threshold_core u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .pix_in    (in_ch),
        .pix_out   (out_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    mean_adaptive_threshold_checker u_checker (
        .clk       (clk),
        .rst_n     (rst_n),
        .pix_in    (in_ch),
        .pix_out   (out_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .errors    (errors),
        .pending   (pending)
    );

    always
    begin
        clk = 1'b1;
        #1;
        clk = 1'b0;
        #1;
    end

    // input handshake seen at the edge, read back at the next falling edge
    always @(posedge clk)
        in_taken <= in_ch.valid && in_ch.ready;

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // Output stalls: always ready, random, or a fixed duty pattern
    always @(negedge clk)
    begin
        stall_cnt++;
        if (stall_cnt % 1500 == 0)
            stall_mode = $urandom_range(0, 2);
        case (stall_mode)
            0: out_ch.ready = 1'b1;
            1: out_ch.ready = $urandom_range(0, 1);
            default: out_ch.ready = (stall_cnt % 7) < 2;
        endcase
    end

    task automatic send_word(input logic cmd, input logic [7:0] pix);
        if (burst_left == 0)
        begin
            if ($urandom_range(0, 1))
            begin
                in_ch.valid = 1'b0;
                repeat ($urandom_range(1, 12)) @(negedge clk);
            end
            burst_left = $urandom_range(1, 40);
        end
        in_ch.valid       = 1'b1;
        in_ch.cmd         = cmd;
        in_ch.pixel_value = pix;
        do @(negedge clk); while (!in_taken);
        burst_left--;
        words_sent++;
    endtask

    task automatic send_pixel(input logic [7:0] pix);
        send_word(mat_pkg::CMD_PIXEL, pix);
    endtask

    // Lets every expected word drain, then a margin for silent work
    task automatic wait_idle();
        in_ch.valid = 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input logic [mat_pkg::CFG_INDEX_W-1:0] idx,
                             input int unsigned val);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = val[mat_pkg::CFG_DATA_W-1:0];
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    task automatic set_frame(input int unsigned w, input int unsigned h,
                             input int unsigned r, input int ofs);
        wait_idle();
        write_reg(mat_pkg::REG_IMAGE_WIDTH, w);
        write_reg(mat_pkg::REG_IMAGE_HEIGHT, h);
        write_reg(mat_pkg::REG_WINDOW_RAD, r);
        write_reg(mat_pkg::REG_THRESH_OFS, ofs & 9'h1FF);
    endtask

    function automatic logic [7:0] rand_luma();
        case ($urandom_range(0, 9))
            0: return 8'd0;
            1: return 8'd255;
            default: return $urandom_range(0, 255);
        endcase
    endfunction

    initial
    begin
        int unsigned w, h, r, n, cut;
        int ofs;
        in_ch.valid = 1'b0;
        in_ch.cmd = mat_pkg::CMD_PIXEL;
        in_ch.pixel_value = 8'd0;
        out_ch.ready = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        stall_mode = 0;
        stall_cnt = 0;
        cycles = 0;
        burst_left = 0;
        words_sent = 0;
        rst_n = 1'b0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Reset geometry: far too few pixels for any result
        send_pixel(8'd0);
        send_pixel(8'd255);
        send_word(mat_pkg::CMD_FLUSH, 8'd0);

        // Zero width and height act as one pixel; lowest offset
        set_frame(0, 0, 0, -256);
        send_pixel(8'd0);
        send_word(mat_pkg::CMD_FLUSH, 8'd255);

        // Oversized geometry, partial frame dropped by the next write
        set_frame(4095, 8191, 7, 255);
        send_pixel(8'd255);
        send_pixel(8'd1);

        set_frame(3, 2, 1, -255);
        send_pixel(8'd0);
        send_pixel(8'd255);
        send_pixel(8'd128);
        send_pixel(8'd1);
        send_pixel(8'd254);
        send_pixel(8'd7);
        repeat (3) send_word(mat_pkg::CMD_FLUSH, 8'd0);

        // Window wider than the frame; a pixel past the end is dropped
        set_frame(2, 2, 7, 255);
        send_pixel(8'd255);
        send_pixel(8'd0);
        send_pixel(8'd255);
        send_pixel(8'd255);
        send_pixel(8'd9);
        repeat (2) send_word(mat_pkg::CMD_FLUSH, 8'd0);

        // Random frames, mostly complete with random content
        words_sent = 0;
        while (words_sent < RANDOM_WORDS)
        begin
            w = ($urandom_range(0, 4) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
            h = $urandom_range(1, 8);
            r = $urandom_range(0, 7);
            case ($urandom_range(0, 5))
                0: ofs = -256;
                1: ofs = 255;
                2: ofs = $urandom_range(0, 511) - 256;
                default: ofs = $urandom_range(0, 20) - 10;
            endcase
            set_frame(w, h, r, ofs);
            n = w * h;
            cut = ($urandom_range(0, 9) == 0) ? $urandom_range(1, n) : n;
            for (int unsigned i = 0; i < cut && words_sent < RANDOM_WORDS; i++)
            begin
                if ($urandom_range(0, 9) == 0)
                    send_word(mat_pkg::CMD_FLUSH, rand_luma());
                send_pixel(rand_luma());
            end
            for (int unsigned i = 0;
                 i < (r + 1) * (w + 1) + 2 && words_sent < RANDOM_WORDS; i++)
            begin
                if ($urandom_range(0, 9) == 0)
                    send_pixel(rand_luma());
                else
                    send_word(mat_pkg::CMD_FLUSH, rand_luma());
            end
        end

        in_ch.valid = 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (errors == 0 && pending == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
